// ===== rtl/rtp_pkg.sv =====
// Shared types and constants for the RTP fixed-header parser.
package rtp_pkg;

  // Fixed header length and the byte position just past the longest CSRC list (saturation point)
  localparam logic [6:0] HDR_LEN = 7'd12;
  localparam logic [6:0] POS_MAX = 7'd72;

  typedef enum logic [1:0] {
    KIND_HEADER  = 2'd0,
    KIND_CSRC    = 2'd1,
    KIND_PAYLOAD = 2'd2,
    KIND_SHORT   = 2'd3
  } kind_t;

  // Parser context carried from byte to byte
  typedef struct packed {
    logic [6:0]  bytes_seen;
    logic [15:0] first_two_bytes;
    logic [15:0] sequence_value;
    logic [31:0] timestamp_value;
    logic [31:0] source_id;
    logic [23:0] partial_word;
  } parse_state_t;

  // One result item
  typedef struct packed {
    kind_t       kind;
    logic [1:0]  version;
    logic        padding;
    logic        extension;
    logic [3:0]  src_count;
    logic        marker;
    logic [6:0]  pay_type;
    logic [15:0] seq_num;
    logic [31:0] timestamp;
    logic [31:0] ssrc;
    logic [31:0] data;
    logic        packet_done;
  } result_t;

endpackage

// ===== rtl/rtp_byte_if.sv =====
// Byte stream channel: one packet byte per transfer with an end-of-packet flag.
interface rtp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       final_byte;

  modport source (output valid, output byte_value, output final_byte, input ready);
  modport sink (input valid, input byte_value, input final_byte, output ready);
endinterface

// ===== rtl/rtp_result_if.sv =====
// Result channel: decoded header, CSRC word, payload byte or short-packet error.
interface rtp_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [1:0]  version;
  logic        padding;
  logic        extension;
  logic [3:0]  src_count;
  logic        marker;
  logic [6:0]  pay_type;
  logic [15:0] seq_num;
  logic [31:0] timestamp;
  logic [31:0] ssrc;
  logic [31:0] data;
  logic        packet_done;

  modport source (
    output valid, input ready,
    output kind, output version, output padding, output extension, output src_count,
    output marker, output pay_type, output seq_num, output timestamp,
    output ssrc, output data, output packet_done
  );
  modport sink (
    input valid, output ready,
    input kind, input version, input padding, input extension, input src_count,
    input marker, input pay_type, input seq_num, input timestamp,
    input ssrc, input data, input packet_done
  );
endinterface

// ===== rtl/rtp_header_parser_core.sv =====
// Top level of the RTP fixed-header parser: input stage, decode, result register.
//
//   channel     | dir | payload                                   | transfer
//   ------------+-----+-------------------------------------------+-----------------
//   byte_in     | in  | byte_value[7:0], final_byte               | valid & ready
//   result_out  | out | kind, header fields, data[31:0], packet_done | valid & ready
//
// One byte per cycle sustained while result_out is not stalled; a byte is held in
// the input register, then decoded into the result register, from which its result
// transfers out.
// rst is synchronous and clears both stage valids and the parser context.
// A stalled result register holds the decode stage; the input register keeps
// taking a byte whenever the decode stage moves on in the same cycle.
module rtp_header_parser_core
  import rtp_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  rtp_byte_if.sink     byte_in,
  rtp_result_if.source result_out
);

  logic         s1_valid;
  logic [7:0]   s1_byte;
  logic         s1_final;
  logic         s1_advance;

  parse_state_t state;
  parse_state_t state_next;
  result_t      dec_result;
  logic         dec_has_result;

  logic         out_valid;
  result_t      out_result;

  // Move the input stage on when the result register is free or draining
  assign s1_advance    = s1_valid && (!out_valid || result_out.ready);
  assign byte_in.ready = !s1_valid || s1_advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (byte_in.ready) begin
      s1_valid <= byte_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_in.valid && byte_in.ready) begin
      s1_byte  <= byte_in.byte_value;
      s1_final <= byte_in.final_byte;
    end
  end

  rtp_decode u_decode (
    .state      (state),
    .byte_value (s1_byte),
    .final_byte (s1_final),
    .state_next (state_next),
    .result     (dec_result),
    .has_result (dec_has_result)
  );

  // Parser context
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (s1_advance) begin
      state <= state_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= dec_has_result;
    end else if (result_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance && dec_has_result) begin
      out_result <= dec_result;
    end
  end

  // Drive the result channel
  assign result_out.valid       = out_valid;
  assign result_out.kind        = out_result.kind;
  assign result_out.version     = out_result.version;
  assign result_out.padding     = out_result.padding;
  assign result_out.extension   = out_result.extension;
  assign result_out.src_count   = out_result.src_count;
  assign result_out.marker      = out_result.marker;
  assign result_out.pay_type    = out_result.pay_type;
  assign result_out.seq_num     = out_result.seq_num;
  assign result_out.timestamp   = out_result.timestamp;
  assign result_out.ssrc        = out_result.ssrc;
  assign result_out.data        = out_result.data;
  assign result_out.packet_done = out_result.packet_done;

  // Byte position never runs past the end of the longest CSRC list
  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    state.bytes_seen <= POS_MAX)
    else $error("byte position beyond saturation point");

  // A final byte restarts the position count
  a_pos_restart: assert property (@(posedge clk) disable iff (rst)
    s1_advance && s1_final |=> state.bytes_seen == 7'd0)
    else $error("position not cleared after final byte");

  // A short-packet error always closes the packet
  a_short_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_result.kind == KIND_SHORT |-> out_result.packet_done)
    else $error("short-packet error without packet_done");

  // A payload byte only occupies the low eight data bits
  a_payload_width: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_result.kind == KIND_PAYLOAD |-> out_result.data[31:8] == 24'h000000)
    else $error("payload item with high data bits set");

  // Results only come from a byte that the decode stage took
  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(s1_advance))
    else $error("result appeared without a decoded byte");

endmodule

// ===== rtl/rtp_decode.sv =====
// Per-byte decode: next parser context and the result item for one byte.
module rtp_decode
  import rtp_pkg::*;
(
  input  parse_state_t state,
  input  logic [7:0]   byte_value,
  input  logic         final_byte,
  output parse_state_t state_next,
  output result_t      result,
  output logic         has_result
);

  logic [6:0] pos;
  logic [7:0] b0;
  logic [7:0] b1;
  logic [3:0] cc;
  logic [6:0] list_end;

  always_comb begin
    pos        = state.bytes_seen;
    state_next = state;
    result     = '0;
    has_result = 1'b0;

    // Shift the byte into the field it belongs to
    if (pos == 7'd0) begin
      state_next.first_two_bytes = {byte_value, 8'h00};
    end else if (pos == 7'd1) begin
      state_next.first_two_bytes = {state.first_two_bytes[15:8], byte_value};
    end else if (pos < 7'd4) begin
      state_next.sequence_value = {state.sequence_value[7:0], byte_value};
    end else if (pos < 7'd8) begin
      state_next.timestamp_value = {state.timestamp_value[23:0], byte_value};
    end else if (pos < HDR_LEN) begin
      state_next.source_id = {state.source_id[23:0], byte_value};
    end

    b0       = state_next.first_two_bytes[15:8];
    b1       = state_next.first_two_bytes[7:0];
    cc       = b0[3:0];
    list_end = HDR_LEN + {1'b0, cc, 2'b00};

    // Pick the result for this position
    if (pos < HDR_LEN - 7'd1) begin
      if (final_byte) begin
        result.kind        = KIND_SHORT;
        result.packet_done = 1'b1;
        has_result         = 1'b1;
      end
    end else if (pos == HDR_LEN - 7'd1) begin
      has_result = 1'b1;
      if (final_byte && cc != 4'd0) begin
        result.kind        = KIND_SHORT;
        result.packet_done = 1'b1;
      end else begin
        result.kind        = KIND_HEADER;
        result.version     = b0[7:6];
        result.padding     = b0[5];
        result.extension   = b0[4];
        result.src_count   = cc;
        result.marker      = b1[7];
        result.pay_type    = b1[6:0];
        result.seq_num     = state_next.sequence_value;
        result.timestamp   = state_next.timestamp_value;
        result.ssrc        = state_next.source_id;
        result.packet_done = final_byte;
      end
    end else if (pos < list_end) begin
      // CSRC words start on a multiple of four, so the low bits give the byte lane
      if (pos[1:0] == 2'd3) begin
        has_result = 1'b1;
        if (final_byte && (pos + 7'd1) != list_end) begin
          result.kind        = KIND_SHORT;
          result.packet_done = 1'b1;
        end else begin
          result.kind        = KIND_CSRC;
          result.data        = {state.partial_word, byte_value};
          result.packet_done = final_byte;
        end
      end else begin
        state_next.partial_word = {state.partial_word[15:0], byte_value};
        if (final_byte) begin
          result.kind        = KIND_SHORT;
          result.packet_done = 1'b1;
          has_result         = 1'b1;
        end
      end
    end else begin
      result.kind        = KIND_PAYLOAD;
      result.data        = {24'h000000, byte_value};
      result.packet_done = final_byte;
      has_result         = 1'b1;
    end

    // Advance the byte position, saturating past the longest CSRC list
    if (final_byte) begin
      state_next.bytes_seen = 7'd0;
    end else if (pos < POS_MAX) begin
      state_next.bytes_seen = pos + 7'd1;
    end
  end

endmodule
